// File: hw/rtl/bmal_pkg.sv
// Shared types and constants of the battery moving-average level block.
package bmal_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WLEN_W   = 7;
  localparam int LEVEL_W  = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int CNT_W    = 4;
  localparam int NUM_W    = SAMPLE_W + LEVEL_W;

  localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_AW-1:0] REG_EMPTY_MV      = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FULL_MV       = 2'd2;

  localparam logic [WLEN_W-1:0]   WLEN_RESET  = 7'd16;
  localparam logic [SAMPLE_W-1:0] EMPTY_RESET = 16'd3000;
  localparam logic [SAMPLE_W-1:0] FULL_RESET  = 16'd4200;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 7'd0;

  localparam logic [CNT_W-1:0] MEAN_STEPS = 4'd15;
  localparam logic [CNT_W-1:0] LVL_STEPS  = 4'd6;

  typedef struct packed {
    logic accept;
    logic zero_res;
    logic update;
    logic mean_load;
    logic div_step;
    logic lvl_eval;
    logic lvl_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic lvl_interp;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/battery_moving_average_level.sv
// Top level of the battery moving-average level block.
//
// Each request carries one voltage sample in millivolts and yields one result: the
// truncated mean of the last window_length samples (at most WINDOW_DEPTH) and a charge
// level from 0 to 100 percent. The block works on one sample at a time: it accepts the
// sample, updates the window memory and running sum, divides for the mean in the shared
// restoring divider (one quotient bit per cycle), compares the mean against the empty
// and full voltages, interpolates the level with the same divider when the mean lies
// between them, and loads the output register once it is free. With window_length zero
// a request skips these steps and yields a result of zeros. The window memory needs no
// clearing pass: a fill count marks which entries hold samples since reset or the last
// window_length write, and older entries read as zero. A finished result waits in the
// output register while the next sample is already being processed.
module battery_moving_average_level #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmal_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bmal_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmal_pkg::SAMPLE_W-1:0] in_sample_mv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmal_pkg::SAMPLE_W-1:0] out_avg_mv,
  output logic [bmal_pkg::LEVEL_W-1:0]  out_level_pct
);
  import bmal_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bmal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmal_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_sample_mv  (in_sample_mv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_avg_mv    (out_avg_mv),
    .out_level_pct (out_level_pct),
    .cmd           (cmd),
    .stat          (stat)
  );

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_pct <= LEVEL_FULL))
    else $error("Level above full scale.");

  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !stat.len_zero) |=> cmd.update)
    else $error("Accepted request was not followed by a window update.");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("Loaded result is not presented.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.update) |-> !in_ready)
    else $error("Input ready while a request is in progress.");
`endif

endmodule

// File: hw/rtl/bmal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/bmal_ctrl.sv
// Controller state machine that sequences the window update and both divisions.
module bmal_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmal_pkg::stat_t stat,
  output bmal_pkg::cmd_t  cmd
);
  import bmal_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_MLOAD = 3'd2;
  localparam logic [2:0] S_MDIV  = 3'd3;
  localparam logic [2:0] S_LVL   = 3'd4;
  localparam logic [2:0] S_LDIV  = 3'd5;
  localparam logic [2:0] S_LTAKE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.len_zero) begin
            cmd.zero_res = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            cmd.accept = 1'b1;
            state_nxt  = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.mean_load = 1'b1;
        cnt_nxt       = MEAN_STEPS;
        state_nxt     = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        cmd.lvl_eval = 1'b1;
        cnt_nxt      = LVL_STEPS;
        state_nxt    = stat.lvl_interp ? S_LDIV : S_OUT;
      end
      S_LDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_LTAKE;
        end
      end
      S_LTAKE: begin
        cmd.lvl_take = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/bmal_dp.sv
// Datapath with configuration registers, sample window, running sum, divider and output register.
module bmal_dp #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmal_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bmal_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [bmal_pkg::SAMPLE_W-1:0] in_sample_mv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmal_pkg::SAMPLE_W-1:0] out_avg_mv,
  output logic [bmal_pkg::LEVEL_W-1:0]  out_level_pct,
  input  bmal_pkg::cmd_t                cmd,
  output bmal_pkg::stat_t               stat
);
  import bmal_pkg::*;

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  logic [WLEN_W-1:0]   win_len_r;
  logic [SAMPLE_W-1:0] empty_r;
  logic [SAMPLE_W-1:0] full_r;
  logic [SUM_W-1:0]    sum_r;
  logic [IDX_W-1:0]    widx_r;
  logic [LEN_W-1:0]    fill_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SAMPLE_W-1:0] dvd_r;
  logic [SAMPLE_W-1:0] quot_r;
  logic [SAMPLE_W-1:0] dsor_r;
  logic [SAMPLE_W-1:0] avg_res_r;
  logic [LEVEL_W-1:0]  lvl_res_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic [LEVEL_W-1:0]  out_lvl_r;
  logic                out_valid_r;

  logic [LEN_W-1:0]    eff_len;
  logic [IDX_W-1:0]    idx_sel;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] old_val;
  logic [31:0]         idx_inc;
  logic [IDX_W-1:0]    widx_nxt;
  logic [31:0]         sum_ext;
  logic [SAMPLE_W:0]   shifted;
  logic                q_bit;
  logic [SAMPLE_W-1:0] diff;
  logic [NUM_W-1:0]    num;
  logic                cfg_len_wr;

  assign eff_len = (32'(win_len_r) > 32'(WINDOW_DEPTH)) ? LEN_W'(WINDOW_DEPTH)
                                                         : LEN_W'(win_len_r);
  assign idx_sel = (32'(widx_r) >= 32'(eff_len)) ? '0 : widx_r;
  assign old_val = (32'(idx_r) < 32'(fill_r)) ? rd_data : '0;
  assign idx_inc = 32'(idx_r) + 32'd1;
  assign widx_nxt = (idx_inc >= 32'(eff_len)) ? '0 : IDX_W'(idx_inc);
  assign sum_ext = 32'(sum_r);
  assign shifted = {rem_r, dvd_r[SAMPLE_W-1]};
  assign q_bit   = (shifted >= {1'b0, dsor_r});
  assign diff    = quot_r - empty_r;
  assign num     = NUM_W'(diff) * NUM_W'(LEVEL_FULL);
  assign cfg_len_wr = cfg_we && (cfg_addr == REG_WINDOW_LENGTH);

  assign stat.len_zero   = (win_len_r == '0);
  assign stat.lvl_interp = (quot_r > empty_r) && (quot_r < full_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  bmal_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (idx_r),
    .wr_data (sample_r),
    .rd_en   (cmd.accept),
    .rd_addr (idx_sel),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WLEN_RESET;
      empty_r   <= EMPTY_RESET;
      full_r    <= FULL_RESET;
      sum_r     <= '0;
      widx_r    <= '0;
      fill_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW_LENGTH: win_len_r <= cfg_wdata[WLEN_W-1:0];
          REG_EMPTY_MV:      empty_r   <= cfg_wdata[SAMPLE_W-1:0];
          REG_FULL_MV:       full_r    <= cfg_wdata[SAMPLE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cfg_len_wr) begin
        sum_r  <= '0;
        widx_r <= '0;
        fill_r <= '0;
      end else if (cmd.update) begin
        sum_r  <= sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
        widx_r <= widx_nxt;
        if (32'(fill_r) < 32'(eff_len)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample_mv;
      idx_r    <= idx_sel;
    end
    if (cmd.mean_load) begin
      rem_r  <= sum_ext[31:16];
      dvd_r  <= sum_ext[15:0];
      dsor_r <= SAMPLE_W'(eff_len);
      quot_r <= '0;
    end else if (cmd.lvl_eval && stat.lvl_interp) begin
      rem_r  <= num[NUM_W-1:LEVEL_W];
      dvd_r  <= {num[LEVEL_W-1:0], {(SAMPLE_W-LEVEL_W){1'b0}}};
      dsor_r <= full_r - empty_r;
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= q_bit ? SAMPLE_W'(shifted - {1'b0, dsor_r}) : shifted[SAMPLE_W-1:0];
      dvd_r  <= {dvd_r[SAMPLE_W-2:0], 1'b0};
      quot_r <= {quot_r[SAMPLE_W-2:0], q_bit};
    end
    if (cmd.zero_res) begin
      avg_res_r <= '0;
      lvl_res_r <= LEVEL_EMPTY;
    end else if (cmd.lvl_eval) begin
      avg_res_r <= quot_r;
      lvl_res_r <= (quot_r <= empty_r) ? LEVEL_EMPTY : LEVEL_FULL;
    end else if (cmd.lvl_take) begin
      lvl_res_r <= quot_r[LEVEL_W-1:0];
    end
    if (cmd.out_load) begin
      out_avg_r <= avg_res_r;
      out_lvl_r <= lvl_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_avg_mv    = out_avg_r;
  assign out_level_pct = out_lvl_r;

endmodule

// File: tb/sv/tb_battery_moving_average_level.sv
// Self-checking testbench of the battery moving-average level block.
module tb_battery_moving_average_level;
  timeunit 1ns;
  timeprecision 1ps;

  import bmal_pkg::*;

  localparam int WINDOW_DEPTH = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_mv;
    logic [LEVEL_W-1:0]  level_pct;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample_mv = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_avg_mv;
  logic [LEVEL_W-1:0]  out_level_pct;

  reading_t    pending_readings[$];
  int unsigned win_mem[WINDOW_DEPTH];
  int unsigned win_sum;
  int unsigned win_pos;
  int unsigned cur_len;
  int unsigned cur_empty;
  int unsigned cur_full;
  int unsigned send_gap_pct = 19;
  int unsigned stall_pct = 56;
  int unsigned stall_cycles = 0;
  int          errors = 0;

  battery_moving_average_level #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_mv (in_sample_mv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_avg_mv   (out_avg_mv),
    .out_level_pct(out_level_pct)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: avg_mv %0d level_pct %0d", out_avg_mv, out_level_pct);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (out_avg_mv !== want.avg_mv) begin
          $error("avg_mv: expected %0d, actual %0d", want.avg_mv, out_avg_mv);
          errors++;
        end
        if (out_level_pct !== want.level_pct) begin
          $error("level_pct: expected %0d, actual %0d", want.level_pct, out_level_pct);
          errors++;
        end
      end
    end
  end

  function automatic void clear_window();
    foreach (win_mem[i]) win_mem[i] = 0;
    win_sum = 0;
    win_pos = 0;
  endfunction

  function automatic logic [LEVEL_W-1:0] charge_level(int unsigned mv);
    if (mv <= cur_empty) return LEVEL_EMPTY;
    if (mv >= cur_full) return LEVEL_FULL;
    return LEVEL_W'(((mv - cur_empty) * 100) / (cur_full - cur_empty));
  endfunction

  function automatic void record_sample(int unsigned mv);
    int unsigned len;
    int unsigned pos;
    reading_t r;
    len = (cur_len > WINDOW_DEPTH) ? WINDOW_DEPTH : cur_len;
    r = '0;
    if (len != 0) begin
      pos = (win_pos >= len) ? 0 : win_pos;
      win_sum = win_sum - win_mem[pos] + mv;
      win_mem[pos] = mv;
      win_pos = (pos + 1 >= len) ? 0 : pos + 1;
      r.avg_mv = SAMPLE_W'(win_sum / len);
      r.level_pct = charge_level(r.avg_mv);
    end
    pending_readings.push_back(r);
  endfunction

  function automatic int unsigned pick_sample();
    int unsigned lo;
    int unsigned hi;
    lo = (cur_empty < cur_full) ? cur_empty : cur_full;
    hi = (cur_empty < cur_full) ? cur_full : cur_empty;
    lo = (lo > 300) ? lo - 300 : 0;
    hi = (hi < 65235) ? hi + 300 : 65535;
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(65535);
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic send_sample(input int unsigned mv);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_mv <= SAMPLE_W'(mv);
    do @(posedge clk); while (!in_ready);
    record_sample(mv);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input int unsigned data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CFG_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      REG_WINDOW_LENGTH: begin
        cur_len = data & 7'h7F;
        clear_window();
      end
      REG_EMPTY_MV: cur_empty = data & 16'hFFFF;
      REG_FULL_MV: cur_full = data & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic test_reset_window();
    send_sample(65535);
    send_sample(0);
    send_sample(4200);
    wait_for_results();
  endtask

  task automatic test_length_extremes();
    write_reg(REG_WINDOW_LENGTH, 1);
    send_sample(65535);
    send_sample(0);
    send_sample(3000);
    send_sample(4200);
    send_sample(3600);
    send_sample(3001);
    send_sample(4199);
    wait_for_results();
    write_reg(REG_WINDOW_LENGTH, 127);
    send_sample(65535);
    send_sample(65535);
    wait_for_results();
    write_reg(REG_WINDOW_LENGTH, WINDOW_DEPTH);
    send_sample(65535);
    wait_for_results();
  endtask

  task automatic test_disabled();
    write_reg(REG_WINDOW_LENGTH, 0);
    send_sample(65535);
    send_sample(12345);
    wait_for_results();
    write_reg(REG_WINDOW_LENGTH, 2);
    send_sample(4000);
    wait_for_results();
  endtask

  task automatic test_empty_above_full();
    write_reg(REG_WINDOW_LENGTH, 1);
    write_reg(REG_EMPTY_MV, 5000);
    write_reg(REG_FULL_MV, 4000);
    send_sample(4999);
    send_sample(5000);
    send_sample(5001);
    wait_for_results();
    write_reg(REG_FULL_MV, 5000);
    send_sample(5000);
    send_sample(5001);
    wait_for_results();
  endtask

  task automatic test_register_writes();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(4800);
    wait_for_results();
    write_reg(REG_WINDOW_LENGTH, 2);
    write_reg(REG_EMPTY_MV, 0);
    write_reg(REG_FULL_MV, 65535);
    send_sample(1000);
    send_sample(1000);
    wait_for_results();
    write_reg(REG_WINDOW_LENGTH, 2);
    send_sample(1000);
    wait_for_results();
  endtask

  task automatic randomize_config();
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(9))
        0: len = 0;
        1: len = 1;
        2: len = WINDOW_DEPTH;
        3: len = $urandom_range(127, WINDOW_DEPTH + 1);
        4: len = 2;
        default: len = $urandom_range(16, 1);
      endcase
      if ($urandom_range(1) == 0) len = len | ($urandom_range(511) << WLEN_W);
      write_reg(REG_WINDOW_LENGTH, len);
    end
    case ($urandom_range(7))
      0: begin
        lo = $urandom_range(65535);
        hi = $urandom_range(65535);
      end
      1: begin
        lo = $urandom_range(65535);
        hi = lo;
      end
      2: begin
        lo = 0;
        hi = 65535;
      end
      default: begin
        lo = $urandom_range(60000);
        hi = lo + $urandom_range(5535, 1);
      end
    endcase
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom_range(65535));
    write_reg(REG_EMPTY_MV, lo);
    write_reg(REG_FULL_MV, hi);
  endtask

  task automatic test_random_samples(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      wait_for_results();
      randomize_config();
      burst = $urandom_range(80, 1);
      if (burst > n_items - sent) burst = n_items - sent;
      repeat (burst) begin
        send_sample(pick_sample());
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    cur_len = WLEN_RESET;
    cur_empty = EMPTY_RESET;
    cur_full = FULL_RESET;
    clear_window();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_length_extremes();
    test_disabled();
    test_empty_above_full();
    test_register_writes();
    test_random_samples(135);
    send_gap_pct = 56;
    stall_pct = 19;
    test_random_samples(135);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_samples(135);

    wait_for_results();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
